// ===== hdl/cid_pkg.sv =====
// Package for the instruction decoder: kind codes, major opcodes, function
// codes and the decode result type. No dependencies.

package cid_pkg;

	typedef logic [5:0]  kind_t;
	typedef logic [5:0]  opcode_t;
	typedef logic [10:0] func_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] word;
	} decode_t;

	// Instruction kinds, alphabetical; the last code marks an illegal word.
	localparam kind_t KIND_ADD      = 6'd0;
	localparam kind_t KIND_ADDI     = 6'd1;
	localparam kind_t KIND_AND      = 6'd2;
	localparam kind_t KIND_ANDI     = 6'd3;
	localparam kind_t KIND_BEQ      = 6'd4;
	localparam kind_t KIND_BGEZ     = 6'd5;
	localparam kind_t KIND_BGEZAL   = 6'd6;
	localparam kind_t KIND_BGTZ     = 6'd7;
	localparam kind_t KIND_BLEZ     = 6'd8;
	localparam kind_t KIND_BLTZ     = 6'd9;
	localparam kind_t KIND_BLTZAL   = 6'd10;
	localparam kind_t KIND_BNE      = 6'd11;
	localparam kind_t KIND_CF       = 6'd12;
	localparam kind_t KIND_EXCHANGE = 6'd13;
	localparam kind_t KIND_J        = 6'd14;
	localparam kind_t KIND_JAL      = 6'd15;
	localparam kind_t KIND_JALR     = 6'd16;
	localparam kind_t KIND_JR       = 6'd17;
	localparam kind_t KIND_NEG      = 6'd18;
	localparam kind_t KIND_NOR      = 6'd19;
	localparam kind_t KIND_OR       = 6'd20;
	localparam kind_t KIND_ORI      = 6'd21;
	localparam kind_t KIND_RL       = 6'd22;
	localparam kind_t KIND_RLV      = 6'd23;
	localparam kind_t KIND_RR       = 6'd24;
	localparam kind_t KIND_RRV      = 6'd25;
	localparam kind_t KIND_SLL      = 6'd26;
	localparam kind_t KIND_SLLV     = 6'd27;
	localparam kind_t KIND_SLT      = 6'd28;
	localparam kind_t KIND_SLTI     = 6'd29;
	localparam kind_t KIND_SRA      = 6'd30;
	localparam kind_t KIND_SRAV     = 6'd31;
	localparam kind_t KIND_SRL      = 6'd32;
	localparam kind_t KIND_SRLV     = 6'd33;
	localparam kind_t KIND_SUB      = 6'd34;
	localparam kind_t KIND_XOR      = 6'd35;
	localparam kind_t KIND_XORI     = 6'd36;
	localparam kind_t KIND_ILLEGAL  = 6'd37;

	// Major opcodes.
	localparam opcode_t OP_REG      = 6'd0;
	localparam opcode_t OP_J        = 6'd1;
	localparam opcode_t OP_JR       = 6'd2;
	localparam opcode_t OP_JAL      = 6'd3;
	localparam opcode_t OP_JALR     = 6'd4;
	localparam opcode_t OP_BLTZ     = 6'd5;
	localparam opcode_t OP_BGEZ     = 6'd6;
	localparam opcode_t OP_BLTZAL   = 6'd7;
	localparam opcode_t OP_BGEZAL   = 6'd8;
	localparam opcode_t OP_BEQ      = 6'd9;
	localparam opcode_t OP_BNE      = 6'd10;
	localparam opcode_t OP_BLEZ     = 6'd11;
	localparam opcode_t OP_BGTZ     = 6'd12;
	localparam opcode_t OP_CF       = 6'd13;
	localparam opcode_t OP_ADDI     = 6'd24;
	localparam opcode_t OP_SLTI     = 6'd26;
	localparam opcode_t OP_ANDI     = 6'd28;
	localparam opcode_t OP_ORI      = 6'd29;
	localparam opcode_t OP_XORI     = 6'd30;
	localparam opcode_t OP_EXCHANGE = 6'd40;

	// Register-type function codes.
	localparam func_t FN_ADD  = 11'h001;
	localparam func_t FN_AND  = 11'h010;
	localparam func_t FN_NEG  = 11'h100;
	localparam func_t FN_NOR  = 11'h080;
	localparam func_t FN_OR   = 11'h020;
	localparam func_t FN_RL   = 11'h440;
	localparam func_t FN_RLV  = 11'h500;
	localparam func_t FN_RR   = 11'h480;
	localparam func_t FN_RRV  = 11'h600;
	localparam func_t FN_SLL  = 11'h401;
	localparam func_t FN_SLLV = 11'h408;
	localparam func_t FN_SLT  = 11'h400;
	localparam func_t FN_SRA  = 11'h404;
	localparam func_t FN_SRAV = 11'h420;
	localparam func_t FN_SRL  = 11'h402;
	localparam func_t FN_SRLV = 11'h410;
	localparam func_t FN_SUB  = 11'h004;
	localparam func_t FN_XOR  = 11'h040;

endpackage

// ===== hdl/cid_in_if.sv =====
// Input channel of the instruction decoder: valid/ready and one
// instruction word. No dependencies.

interface cid_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;

	modport source(output valid, output instruction_word, input ready);
	modport sink(input valid, input instruction_word, output ready);
endinterface

// ===== hdl/cid_out_if.sv =====
// Result channel of the instruction decoder: valid/ready, the kind and
// the raw fields of the word. No dependencies.

interface cid_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  kind;
	logic [5:0]  major_op;
	logic [4:0]  reg_a;
	logic [4:0]  reg_b;
	logic [4:0]  shift_amount;
	logic [10:0] func_code;
	logic [15:0] branch_offset;
	logic [20:0] immediate_value;
	logic [25:0] jump_target;

	modport source(output valid, output kind, output major_op, output reg_a,
		output reg_b, output shift_amount, output func_code,
		output branch_offset, output immediate_value, output jump_target,
		input ready);
	modport sink(input valid, input kind, input major_op, input reg_a,
		input reg_b, input shift_amount, input func_code,
		input branch_offset, input immediate_value, input jump_target,
		output ready);
endinterface

// ===== hdl/cid_decode.sv =====
// Combinational classifier: maps one instruction word to its kind.
// Depends on cid_pkg.

module cid_decode (
	input  logic [31:0]   word,
	output cid_pkg::kind_t kind
);
	import cid_pkg::*;

	opcode_t     op;
	logic [4:0]  ra;
	logic [4:0]  rb;
	logic [4:0]  sh;
	func_t       fn;
	logic [15:0] off;
	logic [25:0] tgt;
	kind_t       reg_kind;
	logic        need_rb_zero;
	logic        fn_hit;

	assign op  = word[31:26];
	assign ra  = word[25:21];
	assign rb  = word[20:16];
	assign sh  = word[15:11];
	assign fn  = word[10:0];
	assign off = word[15:0];
	assign tgt = word[25:0];

	// Register-type lookup; immediate shifts and rotates need rb clear,
	// the rest need the shift amount clear.
	always_comb begin
		reg_kind     = KIND_ILLEGAL;
		need_rb_zero = 1'b0;
		fn_hit       = 1'b1;
		unique case (fn)
			FN_ADD:  reg_kind = KIND_ADD;
			FN_AND:  reg_kind = KIND_AND;
			FN_NEG:  reg_kind = KIND_NEG;
			FN_NOR:  reg_kind = KIND_NOR;
			FN_OR:   reg_kind = KIND_OR;
			FN_RL: begin
				reg_kind     = KIND_RL;
				need_rb_zero = 1'b1;
			end
			FN_RLV:  reg_kind = KIND_RLV;
			FN_RR: begin
				reg_kind     = KIND_RR;
				need_rb_zero = 1'b1;
			end
			FN_RRV:  reg_kind = KIND_RRV;
			FN_SLL: begin
				reg_kind     = KIND_SLL;
				need_rb_zero = 1'b1;
			end
			FN_SLLV: reg_kind = KIND_SLLV;
			FN_SLT:  reg_kind = KIND_SLT;
			FN_SRA: begin
				reg_kind     = KIND_SRA;
				need_rb_zero = 1'b1;
			end
			FN_SRAV: reg_kind = KIND_SRAV;
			FN_SRL: begin
				reg_kind     = KIND_SRL;
				need_rb_zero = 1'b1;
			end
			FN_SRLV: reg_kind = KIND_SRLV;
			FN_SUB:  reg_kind = KIND_SUB;
			FN_XOR:  reg_kind = KIND_XOR;
			default: fn_hit   = 1'b0;
		endcase
	end

	always_comb begin
		kind = KIND_ILLEGAL;
		unique case (op)
			OP_REG: begin
				if (fn_hit && (need_rb_zero ? (rb == 5'd0) : (sh == 5'd0))) begin
					kind = reg_kind;
				end
			end
			OP_J:        kind = KIND_J;
			OP_JR:       if (ra == 5'd0 && off == 16'd0) kind = KIND_JR;
			OP_JAL:      if (rb == 5'd0) kind = KIND_JAL;
			OP_JALR:     if (off == 16'd0) kind = KIND_JALR;
			OP_BLTZ:     if (ra == 5'd0) kind = KIND_BLTZ;
			OP_BGEZ:     if (ra == 5'd0) kind = KIND_BGEZ;
			OP_BLTZAL:   kind = KIND_BLTZAL;
			OP_BGEZAL:   kind = KIND_BGEZAL;
			OP_BEQ:      kind = KIND_BEQ;
			OP_BNE:      kind = KIND_BNE;
			OP_BLEZ:     if (ra == 5'd0) kind = KIND_BLEZ;
			OP_BGTZ:     if (ra == 5'd0) kind = KIND_BGTZ;
			OP_CF:       if (tgt == 26'd0) kind = KIND_CF;
			OP_ADDI:     kind = KIND_ADDI;
			OP_SLTI:     kind = KIND_SLTI;
			OP_ANDI:     kind = KIND_ANDI;
			OP_ORI:      kind = KIND_ORI;
			OP_XORI:     kind = KIND_XORI;
			OP_EXCHANGE: if (off == 16'd0) kind = KIND_EXCHANGE;
			default:     kind = KIND_ILLEGAL;
		endcase
	end
endmodule

// ===== hdl/custom_isa_instruction_decoder_core.sv =====
// Top level of the instruction decoder: input register, classifier and
// result register. Depends on cid_pkg, cid_in_if, cid_out_if, cid_decode.
//
// Usage
// The instr channel takes one 32-bit instruction word per item; the decoded
// channel returns one item per word, holding the kind (0 to 36, or 37 for an
// illegal word) and every raw field of the word, extracted whatever the kind.
// Both channels use valid/ready; an item moves on a clock edge where both
// are high.
// An accepted item lands in the input register, is classified by a single
// pass of decode logic, and is captured in the result register, where it
// is presented. Throughput is one item per cycle while decoded.ready is
// high; the two registers form a two-deep pipeline, and each stage advances
// whenever the stage after it is empty or being emptied, so a word is taken
// while a finished result still waits.
// When the receiver holds ready low the result register keeps its item and
// the input register fills; instr.ready then falls until decoded.ready
// returns. Nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) empties both stages; there is no
// configuration and no stored state beyond the pipeline.

module custom_isa_instruction_decoder_core (
	input  logic clk,
	input  logic arst_n,
	cid_in_if.sink    instr,
	cid_out_if.source decoded
);
	import cid_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        valid_s2;
	decode_t     result_s2;
	logic        advance_s2;
	logic        advance_s1;
	kind_t       kind_comb;

	// Stage two may load when empty or when its item leaves this cycle.
	assign advance_s2 = !valid_s2 || decoded.ready;
	assign advance_s1 = !valid_s1 || advance_s2;
	assign instr.ready = advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && instr.valid) begin
			word_s1 <= instr.instruction_word;
		end
	end

	cid_decode u_decode (
		.word (word_s1),
		.kind (kind_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			result_s2.kind <= kind_comb;
			result_s2.word <= word_s1;
		end
	end

	assign decoded.valid           = valid_s2;
	assign decoded.kind            = result_s2.kind;
	assign decoded.major_op        = result_s2.word[31:26];
	assign decoded.reg_a           = result_s2.word[25:21];
	assign decoded.reg_b           = result_s2.word[20:16];
	assign decoded.shift_amount    = result_s2.word[15:11];
	assign decoded.func_code       = result_s2.word[10:0];
	assign decoded.branch_offset   = result_s2.word[15:0];
	assign decoded.immediate_value = result_s2.word[20:0];
	assign decoded.jump_target     = result_s2.word[25:0];

`ifndef SYNTH
	// An accepted word always occupies the input register next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(instr.valid && instr.ready) |=> valid_s1)
		else $error("accepted item did not reach the input register");

	// A word in stage one moves on when stage two is empty.
	a_s1_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("item stuck in the input register");

	// A stalled result keeps its contents.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !decoded.ready) |=> (valid_s2 && $stable(result_s2)))
		else $error("stalled result changed");

	// The kind code never exceeds the illegal code.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid |-> (decoded.kind <= KIND_ILLEGAL))
		else $error("kind out of range");

	// A register-type kind (checked here for ADD and SLL) is only given for the register opcode.
	a_reg_kind_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		(decoded.valid && (decoded.kind == KIND_ADD || decoded.kind == KIND_SLL))
		|-> (decoded.major_op == OP_REG))
		else $error("register kind with non-zero opcode");
`endif
endmodule
